// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is held low
`define PLE_ASSERT_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define PLE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ple_pkg.sv -----
// shared types and codes for the positional list engine
// no dependencies
package ple_pkg;

  // operation codes
  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_POS  = 3'd2;
  localparam logic [2:0] OP_DEL_HEAD = 3'd3;
  localparam logic [2:0] OP_DEL_TAIL = 3'd4;
  localparam logic [2:0] OP_DEL_POS  = 3'd5;
  localparam logic [2:0] OP_READ     = 3'd6;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;
  // cell index width, enough for the largest supported list
  localparam int unsigned IDX_W  = 8;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     rd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

// ----- rtl/core/ple_cell.sv -----
// one storage cell of the list chain: holds a single entry
// depends on ple_pkg
module ple_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                            clk,
  input  ple_pkg::cell_ctl_t              ctl,
  input  logic signed [ple_pkg::DATA_W-1:0] left_val,
  input  logic signed [ple_pkg::DATA_W-1:0] right_val,
  output logic signed [ple_pkg::DATA_W-1:0] val,
  output logic signed [ple_pkg::DATA_W-1:0] rd_val
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  // insert shifts toward the tail, delete pulls from the tail side
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && (MY_IDX > ctl.idx)) begin
      val_nxt = left_val;
    end else if (ctl.ins && (MY_IDX == ctl.idx)) begin
      val_nxt = ctl.data;
    end else if (ctl.del && (MY_IDX >= ctl.idx)) begin
      val_nxt = right_val;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // read tap, zero unless this cell is addressed
  assign rd_val = (ctl.rd && (MY_IDX == ctl.idx)) ? val_r : '0;
  assign val    = val_r;

endmodule

// ----- rtl/core/positional_list_engine_unit.sv -----
// Positional list engine: ordered list of signed 32-bit entries in a chain of cells.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle; in_ready is high while the output register
// is empty or being drained, and the addressed cell and those toward the tail shift in the accepting cycle.
// Reset clears the entry count and the output valid; cell contents stay unset.
// Depends on ple_pkg and ple_cell.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [4:0]         out_length
);
  import ple_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 8) ? CW + 1 : 9;

  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  logic [1:0]               status_r;
  logic [1:0]               status_nxt;
  logic signed [DATA_W-1:0] read_value_r;
  logic signed [DATA_W-1:0] rd_or;
  logic [4:0]               length_r;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     pos_ok;
  logic [XW-1:0]            count_x;
  logic [XW-1:0]            pos_x;
  logic                     ins_d;
  logic                     del_d;
  logic                     rd_d;
  logic [IDX_W-1:0]         idx_d;
  cell_ctl_t                ctl;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd  [CAPACITY];

  // handshake
  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign count_x = XW'(count_r);
  assign pos_x   = XW'(in_position);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_ok  = (in_position != 8'd0) && (pos_x <= count_x);

  // operation decode
  always_comb begin
    ins_d      = 1'b0;
    del_d      = 1'b0;
    rd_d       = 1'b0;
    idx_d      = '0;
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    unique case (in_operation) inside
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ins_d     = 1'b1;
          count_nxt = count_r + CW'(1);
          if (in_operation == OP_INS_HEAD) begin
            idx_d = '0;
          end else if (in_operation == OP_INS_TAIL) begin
            idx_d = IDX_W'(count_r);
          end else if (in_position <= 8'd1) begin
            idx_d = '0;
          end else if ((pos_x - XW'(1)) > count_x) begin
            idx_d = IDX_W'(count_r);
          end else begin
            idx_d = in_position - 8'd1;
          end
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (empty) begin
          status_nxt = ST_RANGE;
        end else begin
          del_d     = 1'b1;
          count_nxt = count_r - CW'(1);
          idx_d     = (in_operation == OP_DEL_HEAD) ? '0 : IDX_W'(count_r - CW'(1));
        end
      end
      OP_DEL_POS, OP_READ: begin
        if (!pos_ok) begin
          status_nxt = ST_RANGE;
        end else if (in_operation == OP_DEL_POS) begin
          del_d     = 1'b1;
          count_nxt = count_r - CW'(1);
          idx_d     = in_position - 8'd1;
        end else begin
          rd_d  = 1'b1;
          idx_d = in_position - 8'd1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // broadcast to the chain, shifts only on an accepted beat
  always_comb begin
    ctl.ins  = ins_d && accept;
    ctl.del  = del_d && accept;
    ctl.rd   = rd_d;
    ctl.idx  = idx_d;
    ctl.data = in_value;
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_head
      assign left_v = in_value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    ple_cell #(.POS(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  // combine read taps, at most one is nonzero
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      read_value_r <= rd_or;
      length_r     <= 5'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = read_value_r;
  assign out_length     = length_r;

endmodule

// ----- rtl/core/ple_checker.sv -----
// port-level checker for the positional list engine, bound to the top level
// depends on ple_pkg and assert_macros.svh
`include "assert_macros.svh"

module ple_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_read_value,
  input logic [4:0]         out_length
);
  import ple_pkg::*;

  // a stalled result beat holds its payload
  `PLE_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_read_value) && $stable(out_length))

  // an empty output register never back-pressures the input
  `PLE_ASSERT_ALWAYS(a_ready_when_empty, clk, !out_valid |-> in_ready)

  // a full report carries the full length
  `PLE_ASSERT_RST(a_full_length, clk, rst_n, out_valid && out_status == ST_FULL |-> out_length == 5'(CAPACITY))

  // only a successful beat carries read data
  `PLE_ASSERT_RST(a_read_ok, clk, rst_n, out_valid && out_read_value != 32'sd0 |-> out_status == ST_DONE)

endmodule

bind positional_list_engine_unit ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);
